// ===== rtl/dmht_pkg.sv =====
// ----------------------------------------------------------------------------
// dmht_pkg
// Shared types and constants for the direct-mapped hash table.
// ----------------------------------------------------------------------------
package dmht_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int KEY_W       = 64;
  localparam int CFG_W       = 13;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W       = SIZE_W;
  localparam int TRIAL_W     = IDX_W + 1;
  localparam int PERMILLE    = 1000;
  localparam int PROD_W      = $clog2(TABLE_DEPTH * PERMILLE + 1);
  localparam int STEP_W      = $clog2(KEY_W + 1);
  localparam int FILL_W      = 10;
  localparam int VAL_W       = 16;
  localparam int DEP_W       = 8;
  localparam int ENT_W       = 1 + DEP_W + VAL_W;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_MOD_GO,
    S_MOD_WAIT,
    S_READ,
    S_CHECK,
    S_CLEAR,
    S_FILL_GO,
    S_FILL_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [DEP_W-1:0]        depth;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] found_value;
    logic [DEP_W-1:0]        found_depth;
    logic                    stored;
    logic [FILL_W-1:0]       fill_permille;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [STEP_W-1:0]  steps;
    logic [KEY_W-1:0]   dividend;
    logic [TRIAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [PROD_W-1:0] quotient;
    logic [IDX_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// ===== rtl/dmht_div.sv =====
// ----------------------------------------------------------------------------
// dmht_div
// Restoring serial divider, one quotient bit per cycle, dividend MSB first.
// ----------------------------------------------------------------------------
module dmht_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dmht_pkg::div_req_t req,
  output dmht_pkg::div_rsp_t rsp
);
  import dmht_pkg::*;

  logic [KEY_W-1:0]   dvd_r;
  logic [IDX_W-1:0]   rem_r;
  logic [TRIAL_W-1:0] dsr_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               busy_r;

  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W-1:0] diff;
  logic               ge;

  assign trial = {rem_r, dvd_r[KEY_W-1]};
  assign ge    = (trial >= dsr_r);
  assign diff  = trial - dsr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[KEY_W-2:0], ge};
      rem_r <= ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.quotient  = dvd_r[PROD_W-1:0];
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/direct_mapped_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_top
// Direct-mapped table of search entries: lookup, insert-if-empty, clear.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  in      | in_valid, in_stall, in_data    | item in
//  out     | out_valid, out_stall, out_data | result out
//  cfg     | cfg_valid, cfg_ready, cfg_data | table size write
//
//  Lookup/insert: the 64-step key modulo, then the 22-step fill divide,
//  both in the shared serial divider. Other codes: the fill divide only.
//  Clear: sweep of all 4096 entry memory words, then the fill divide.
//  After reset the same sweep runs before the first transfer in.
//  One item at a time; the result register lets the next item in while
//  a result is stalled.
// ----------------------------------------------------------------------------
module direct_mapped_hash_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dmht_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dmht_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dmht_pkg::CFG_W-1:0]    cfg_data
);
  import dmht_pkg::*;

  state_t state_r, state_nxt;

  in_item_t          item_r;
  logic [CFG_W-1:0]  size_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  clr_idx_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              res_hit_r;
  logic [VAL_W-1:0]  res_val_r;
  logic [DEP_W-1:0]  res_dep_r;
  logic              res_stored_r;

  logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];
  logic [ENT_W-1:0]  ent_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  key_rd_r;
  logic [ENT_W-1:0]  ent_rd_r;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [SIZE_W-1:0] eff_size;
  logic [PROD_W-1:0] fill_prod;
  logic [FILL_W-1:0] fill_sat;
  logic [IDX_W-1:0]  slot;
  logic              accept;
  logic              rd_en;
  logic              ins_we;
  logic              clr_we;
  logic              sweep_last;
  logic              resp_load;
  logic              slot_full;
  logic              key_match;

  dmht_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    priority if (size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_r > CFG_W'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = SIZE_W'(size_r);
    end
  end

  assign slot       = div_rsp.remainder;
  assign fill_prod  = PROD_W'(count_r * PROD_W'(PERMILLE));
  assign fill_sat   = (div_rsp.quotient > PROD_W'(PERMILLE)) ? FILL_W'(PERMILLE)
                                                             : div_rsp.quotient[FILL_W-1:0];
  assign sweep_last = (clr_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign slot_full  = ent_rd_r[ENT_W-1];
  assign key_match  = (key_rd_r == item_r.key);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_data.operation))
            OP_LOOKUP, OP_INSERT: state_nxt = S_MOD_GO;
            OP_CLEAR:             state_nxt = S_CLEAR;
            default:              state_nxt = S_FILL_GO;
          endcase
        end
      end
      S_MOD_GO:    state_nxt = S_MOD_WAIT;
      S_MOD_WAIT: begin
        if (!div_rsp.busy) state_nxt = S_READ;
      end
      S_READ:      state_nxt = S_CHECK;
      S_CHECK:     state_nxt = S_FILL_GO;
      S_CLEAR: begin
        if (sweep_last) state_nxt = S_FILL_GO;
      end
      S_FILL_GO:   state_nxt = S_FILL_WAIT;
      S_FILL_WAIT: begin
        if (!div_rsp.busy) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_INIT;
    endcase
  end

  // outputs
  always_comb begin
    accept           = 1'b0;
    rd_en            = 1'b0;
    ins_we           = 1'b0;
    clr_we           = 1'b0;
    resp_load        = 1'b0;
    div_req.start    = 1'b0;
    div_req.steps    = STEP_W'(KEY_W);
    div_req.dividend = item_r.key;
    div_req.divisor  = TRIAL_W'(eff_size);
    unique case (state_r)
      S_INIT, S_CLEAR: clr_we = 1'b1;
      S_IDLE:          accept = in_valid;
      S_MOD_GO:        div_req.start = 1'b1;
      S_READ:          rd_en = 1'b1;
      S_CHECK:         ins_we = (op_t'(item_r.operation) == OP_INSERT) && !slot_full;
      S_FILL_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(PROD_W);
        div_req.dividend = {fill_prod, {(KEY_W-PROD_W){1'b0}}};
      end
      S_RESP:          resp_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      size_r      <= CFG_W'(TABLE_DEPTH);
      count_r     <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) size_r <= cfg_data;
      if (accept && (op_t'(in_data.operation) == OP_CLEAR)) begin
        count_r <= '0;
      end else if (ins_we) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (clr_we) clr_idx_r <= sweep_last ? '0 : clr_idx_r + IDX_W'(1);
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r       <= in_data;
      res_hit_r    <= 1'b0;
      res_val_r    <= '0;
      res_dep_r    <= '0;
      res_stored_r <= 1'b0;
    end
    if (state_r == S_CHECK) begin
      if ((op_t'(item_r.operation) == OP_LOOKUP) && slot_full && key_match) begin
        res_hit_r <= 1'b1;
        res_val_r <= ent_rd_r[VAL_W-1:0];
        res_dep_r <= ent_rd_r[VAL_W+DEP_W-1:VAL_W];
      end
      res_stored_r <= ins_we;
    end
    if (resp_load) begin
      out_data_r.hit           <= res_hit_r;
      out_data_r.found_value   <= res_val_r;
      out_data_r.found_depth   <= res_dep_r;
      out_data_r.stored        <= res_stored_r;
      out_data_r.fill_permille <= fill_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_we) key_mem[slot] <= item_r.key;
    if (rd_en)  key_rd_r <= key_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      ent_mem[clr_idx_r] <= '0;
    end else if (ins_we) begin
      ent_mem[slot] <= {1'b1, item_r.depth, item_r.value};
    end
    if (rd_en) ent_rd_r <= ent_mem[slot];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("filled count above table depth");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (SIZE_W'(slot) < eff_size))
    else $error("slot index outside table size");

  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response state");

  a_hit_xor_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.hit && out_data_r.stored))
    else $error("result both hit and stored");

endmodule
